// ===== rtl/core/text_full_justify_core_defines.svh =====
// Assertion macros for the text full-justify core.
// Needs clk and arst_n in the scope of the module that uses them.
`ifndef TEXT_FULL_JUSTIFY_CORE_DEFINES_SVH
`define TEXT_FULL_JUSTIFY_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// condition checked at every clock edge out of reset
`define TFJ_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
// antecedent this cycle implies consequent next cycle
`define TFJ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define TFJ_ASSERT(lbl, expr, msg)
`define TFJ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/core/tfj_pkg.sv =====
// Shared constants and types for the text full-justify core.
// No dependencies; used by tfj_div and text_full_justify_core.
package tfj_pkg;

	// default line capacity in characters
	localparam int MAX_WIDTH_DEF = 32;

	// space character used for gaps and padding
	localparam logic [7:0] SPACE_CHAR = 8'd32;

	// register map: index of each register, and reset value
	localparam logic REG_LINE_WIDTH = 1'b0;
	localparam logic [5:0] LINE_WIDTH_RST = 6'd32;

	// status of the shared divider
	typedef struct packed {
		logic busy;
		logic done;
	} tfj_div_stat_t;

endpackage

// ===== rtl/core/tfj_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on tfj_pkg for its status type.
module tfj_div #(
	parameter int N_W = 6,
	parameter int D_W = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [N_W-1:0]        dividend,
	input  logic [D_W-1:0]        divisor,
	output logic [N_W-1:0]        quo,
	output logic [D_W-1:0]        rem,
	output tfj_pkg::tfj_div_stat_t stat
);

	localparam int C_W = $clog2(N_W + 1);

	logic            busy_q;
	logic            done_q;
	logic [C_W-1:0]  cnt_q;
	logic [N_W-1:0]  quo_q;
	logic [D_W-1:0]  rem_q;
	logic [D_W:0]    trial;
	logic            take;

	// trial subtract of the shifted partial remainder
	assign trial = {rem_q, quo_q[N_W-1]};
	assign take  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= C_W'(N_W);
			end else if (busy_q) begin
				if (cnt_q == C_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - C_W'(1);
			end
		end
	end

	// datapath: shift quotient in, keep remainder below divisor
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= (quo_q << 1) | N_W'(take);
			if (take) begin
				rem_q <= D_W'(trial - {1'b0, divisor});
			end else begin
				rem_q <= trial[D_W-1:0];
			end
		end
	end

	assign quo       = quo_q;
	assign rem       = rem_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ===== rtl/core/text_full_justify_core.sv =====
// Greedy full-justify core: letters in, one justified character per output request.
// A letter that does not end a word is taken and the core stays idle. A word end is
// taken and then holds the input off while the word's letters are copied into the line
// and the word is closed into it; when the word does not fit, the held line goes out
// first: a setup state, then a wait on the shared divider that splits the spare
// spaces (a line of one word skips the divider), then one character per cycle, as many
// as the line width, as fast as the sink takes them.
// At the end of the text the last line follows the same way without the divider.
// The input is not ready during this.
// Depends on tfj_pkg, tfj_div and text_full_justify_core_defines.svh.
`include "text_full_justify_core_defines.svh"

module text_full_justify_core #(
	parameter int MAX_WIDTH = tfj_pkg::MAX_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input letter stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] letter
	input  logic        s_tlast,   // word_end
	input  logic        s_tuser,   // [0] text_end
	// output character stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_char
	output logic        m_tlast,   // line_last
	output logic        m_tuser,   // [0] text_last
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CNT_W    = $clog2(MAX_WIDTH + 1);
	localparam int WORD_CAP = (MAX_WIDTH + 1) / 2;
	localparam int WC_W     = $clog2(WORD_CAP + 1);
	localparam int LI_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WI_W     = (WORD_CAP > 1) ? $clog2(WORD_CAP) : 1;
	localparam int SUM_W    = CNT_W + 2;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_JSET = 3'd1;
	localparam logic [2:0] S_JDIV = 3'd2;
	localparam logic [2:0] S_EMIT = 3'd3;
	localparam logic [2:0] S_COPY = 3'd4;

	logic [2:0]        state_q;
	logic [5:0]        line_width_q;
	logic [CNT_W-1:0]  w_eff;

	// line and pending word storage
	logic [7:0]        line_letters [MAX_WIDTH];
	logic [CNT_W-1:0]  word_lens    [WORD_CAP];
	logic [7:0]        pending_word [MAX_WIDTH];

	logic [WC_W-1:0]   count_q;
	logic [CNT_W-1:0]  total_q;
	logic [CNT_W-1:0]  pend_len_q;
	logic              te_q;

	// copy counters
	logic [CNT_W-1:0]  copy_k_q;
	logic [CNT_W-1:0]  added_q;

	// emitter state
	logic [CNT_W-1:0]  char_cnt_q;
	logic [WC_W-1:0]   word_i_q;
	logic [CNT_W-1:0]  k_q;
	logic [CNT_W-1:0]  pos_q;
	logic              gap_ph_q;
	logic [CNT_W-1:0]  gap_rem_q;
	logic [CNT_W-1:0]  each_q;
	logic [WC_W-1:0]   extra_q;
	logic              emit_text_q;

	// output register
	logic              m_valid_q;
	logic [7:0]        m_data_q;
	logic              m_last_q;
	logic              m_user_q;

	// divider hookup
	logic              div_start;
	logic [CNT_W-1:0]  div_quo;
	logic [WC_W-1:0]   div_rem;
	logic [WC_W-1:0]   gaps;
	logic [CNT_W-1:0]  spare;
	logic [CNT_W-1:0]  spaces;
	tfj_pkg::tfj_div_stat_t div_stat;

	logic              in_acc;
	logic              in_word_end;
	logic              append;
	logic [CNT_W-1:0]  pend_nxt;
	logic              fits;
	logic              out_free;
	logic              copy_more;
	logic              count_room;
	logic              letter_wr;
	logic              len_wr;
	logic              pend_wr;
	logic [CNT_W-1:0]  cur_len;
	logic              buf_done;
	logic [CNT_W-1:0]  gap_len;
	logic [7:0]        emit_char;
	logic              emit_last;
	logic              cfg_wr;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == tfj_pkg::REG_LINE_WIDTH);
	assign prdata = (paddr[2] == tfj_pkg::REG_LINE_WIDTH) ? {26'd0, line_width_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= tfj_pkg::LINE_WIDTH_RST;
		end else if (cfg_wr) begin
			line_width_q <= pwdata[5:0];
		end
	end

	// clamp the programmed width into 1..MAX_WIDTH
	always_comb begin
		if (line_width_q == 6'd0) begin
			w_eff = CNT_W'(1);
		end else if (line_width_q > MAX_WIDTH) begin
			w_eff = CNT_W'(MAX_WIDTH);
		end else begin
			w_eff = line_width_q[CNT_W-1:0];
		end
	end

	// intake and fit check
	assign s_tready    = (state_q == S_IDLE);
	assign in_acc      = s_tvalid && s_tready;
	assign in_word_end = s_tlast || s_tuser;
	assign append      = pend_len_q < w_eff;
	assign pend_nxt    = pend_len_q + CNT_W'(append);
	assign pend_wr     = in_acc && append;
	assign count_room  = count_q < WC_W'(WORD_CAP);
	assign fits        = (count_q == '0) ||
		(count_room && ((SUM_W'(total_q) + SUM_W'(count_q) + SUM_W'(pend_nxt)) <= SUM_W'(w_eff)));

	// copy of the pending word into the line
	assign copy_more = count_room && (copy_k_q < pend_len_q);
	assign letter_wr = (state_q == S_COPY) && copy_more && (total_q < CNT_W'(MAX_WIDTH));
	assign len_wr    = (state_q == S_COPY) && !copy_more && count_room;

	// gap split for the justified line
	assign gaps   = count_q - WC_W'(1);
	assign spare  = (w_eff > total_q) ? (w_eff - total_q) : '0;
	assign spaces = (spare < CNT_W'(gaps)) ? CNT_W'(gaps) : spare;
	assign div_start = (state_q == S_JSET) && (count_q >= WC_W'(2));

	tfj_div #(
		.N_W (CNT_W),
		.D_W (WC_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (spaces),
		.divisor  (gaps),
		.quo      (div_quo),
		.rem      (div_rem),
		.stat     (div_stat)
	);

	// next character of the line
	assign out_free  = !m_valid_q || m_tready;
	assign cur_len   = word_lens[word_i_q[WI_W-1:0]];
	assign buf_done  = word_i_q >= count_q;
	assign gap_len   = each_q + CNT_W'(word_i_q < extra_q);
	assign emit_last = char_cnt_q == (w_eff - CNT_W'(1));
	assign emit_char = (gap_ph_q || buf_done) ? tfj_pkg::SPACE_CHAR
		: line_letters[pos_q[LI_W-1:0]];

	// storage writes
	always_ff @(posedge clk) begin
		if (pend_wr) begin
			pending_word[pend_len_q[LI_W-1:0]] <= s_tdata;
		end
		if (letter_wr) begin
			line_letters[total_q[LI_W-1:0]] <= pending_word[copy_k_q[LI_W-1:0]];
		end
		if (len_wr) begin
			word_lens[count_q[WI_W-1:0]] <= added_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			total_q     <= '0;
			pend_len_q  <= '0;
			te_q        <= 1'b0;
			copy_k_q    <= '0;
			added_q     <= '0;
			char_cnt_q  <= '0;
			word_i_q    <= '0;
			k_q         <= '0;
			pos_q       <= '0;
			gap_ph_q    <= 1'b0;
			gap_rem_q   <= '0;
			each_q      <= '0;
			extra_q     <= '0;
			emit_text_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						pend_len_q <= pend_nxt;
						te_q       <= s_tuser;
						copy_k_q   <= '0;
						added_q    <= '0;
						if (in_word_end) begin
							state_q <= fits ? S_COPY : S_JSET;
						end
					end
				end
				S_JSET: begin
					char_cnt_q  <= '0;
					word_i_q    <= '0;
					k_q         <= '0;
					pos_q       <= '0;
					gap_ph_q    <= 1'b0;
					emit_text_q <= 1'b0;
					if (count_q >= WC_W'(2)) begin
						state_q <= S_JDIV;
					end else begin
						each_q  <= CNT_W'(1);
						extra_q <= '0;
						state_q <= S_EMIT;
					end
				end
				S_JDIV: begin
					if (div_stat.done) begin
						each_q  <= div_quo;
						extra_q <= div_rem;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						char_cnt_q <= char_cnt_q + CNT_W'(1);
						// walk letters and gaps of the held line
						if (gap_ph_q) begin
							if (gap_rem_q == CNT_W'(1)) begin
								gap_ph_q <= 1'b0;
								word_i_q <= word_i_q + WC_W'(1);
								k_q      <= '0;
							end else begin
								gap_rem_q <= gap_rem_q - CNT_W'(1);
							end
						end else if (!buf_done) begin
							pos_q <= pos_q + CNT_W'(1);
							if ((k_q + CNT_W'(1)) == cur_len) begin
								k_q <= '0;
								if ((word_i_q + WC_W'(1)) < count_q) begin
									gap_ph_q  <= 1'b1;
									gap_rem_q <= gap_len;
								end else begin
									word_i_q <= word_i_q + WC_W'(1);
								end
							end else begin
								k_q <= k_q + CNT_W'(1);
							end
						end
						// line finished: clear it
						if (emit_last) begin
							count_q <= '0;
							total_q <= '0;
							state_q <= emit_text_q ? S_IDLE : S_COPY;
						end
					end
				end
				S_COPY: begin
					if (copy_more) begin
						copy_k_q <= copy_k_q + CNT_W'(1);
						if (letter_wr) begin
							total_q <= total_q + CNT_W'(1);
							added_q <= added_q + CNT_W'(1);
						end
					end else begin
						if (count_room) begin
							count_q <= count_q + WC_W'(1);
						end
						pend_len_q <= '0;
						copy_k_q   <= '0;
						added_q    <= '0;
						if (te_q) begin
							char_cnt_q  <= '0;
							word_i_q    <= '0;
							k_q         <= '0;
							pos_q       <= '0;
							gap_ph_q    <= 1'b0;
							each_q      <= CNT_W'(1);
							extra_q     <= '0;
							emit_text_q <= 1'b1;
							state_q     <= S_EMIT;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output valid flag: load on a new character, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if ((state_q == S_EMIT) && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// output payload register
	always_ff @(posedge clk) begin
		if ((state_q == S_EMIT) && out_free) begin
			m_data_q <= emit_char;
			m_last_q <= emit_last;
			m_user_q <= emit_last && emit_text_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q;
	assign m_tuser  = m_user_q;

	// checks
	`TFJ_ASSERT(a_each_nonzero, !div_stat.done || (div_quo != '0), "gap share of zero")
	`TFJ_ASSERT_NEXT(a_word_end_busy, in_acc && in_word_end, !s_tready, "ready after word end")
	`TFJ_ASSERT(a_total_bound, total_q <= CNT_W'(MAX_WIDTH), "line letters overflow")
	`TFJ_ASSERT(a_count_bound, count_q <= WC_W'(WORD_CAP), "line word count overflow")

endmodule
